@@ sv/rtce_pkg.sv @@
// Shared types, constants and helpers for the CMOS RTC to epoch seconds block.
// No dependencies; imported by every module of the block.
package rtce_pkg;

    // register indexes on the configuration port
    typedef enum logic [1:0] {
        CFG_BINARY_MODE     = 2'd0,
        CFG_HOUR24_MODE     = 2'd1,
        CFG_CENTURY_PRESENT = 2'd2
    } t_cfg_idx;

    localparam logic [7:0]  PM_BIT_MASK     = 8'h80;
    localparam logic [7:0]  HOUR_12H_MASK   = 8'h7F;
    localparam logic [7:0]  DEFAULT_CENTURY = 8'd20;
    localparam logic [13:0] MIN_YEAR        = 14'd1601;
    localparam logic [13:0] MAX_YEAR        = 14'd9999;
    // leap days 1601..1969 plus L(1600), L(n) = n/4 - n/100 + n/400
    localparam logic [11:0] LEAP_BIAS       = 12'd388 + 12'd89;
    localparam logic [14:0] UNIX_BASE_YEAR  = 15'd1970;

    typedef struct packed {
        logic binary_mode;
        logic hour24_mode;
        logic century_present;
    } t_cfg;

    // after field decode
    typedef struct packed {
        logic        ok;
        logic [5:0]  sec;
        logic [5:0]  min;
        logic [4:0]  hour;
        logic [7:0]  day;
        logic [3:0]  mon;
        logic [6:0]  yy;
        logic [6:0]  cen;
        logic [13:0] year;
    } t_dec;

    // after calendar checks
    typedef struct packed {
        logic               ok;
        logic signed [14:0] ydiff;
        logic signed [12:0] leapd;
        logic        [8:0]  doy;
        logic        [4:0]  hour;
        logic        [5:0]  min;
        logic        [5:0]  sec;
    } t_cal;

    // day count and time of day
    typedef struct packed {
        logic               ok;
        logic signed [23:0] days;
        logic        [16:0] tod;
    } t_days;

    // day count scaled to seconds
    typedef struct packed {
        logic               ok;
        logic signed [39:0] prod;
        logic        [16:0] tod;
    } t_prod;

    function automatic logic [7:0] bcd_dec(input logic [7:0] v, input logic bin);
        logic [7:0] d;
        d = ({4'd0, v[7:4]} * 8'd10) + {4'd0, v[3:0]};
        return bin ? v : d;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] mon);
        logic [4:0] n;
        unique case (mon)
            4'd2:                    n = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
            default:                 n = 5'd31;
        endcase
        return n;
    endfunction

    function automatic logic [8:0] month_start(input logic [3:0] mon);
        logic [8:0] n;
        unique case (mon)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

@@ sv/rtce_decode.sv @@
// Stage 1: BCD decode, 12/24-hour mapping, field range checks, full year.
// Depends on rtce_pkg.
module rtce_decode (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_ce,
    input  rtce_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    input  logic [55:0]   i_data,
    output logic          o_valid,
    output rtce_pkg::t_dec o_dec
);
    import rtce_pkg::*;

    logic       r_valid;
    t_dec       r_dec;
    t_dec       n_dec;
    logic [7:0] sec, min, day, mon, yy, cen, hraw, h8;
    logic       pm, ok_h;

    always_comb begin
        sec  = bcd_dec(i_data[7:0],   i_cfg.binary_mode);
        min  = bcd_dec(i_data[15:8],  i_cfg.binary_mode);
        hraw = i_data[23:16];
        day  = bcd_dec(i_data[31:24], i_cfg.binary_mode);
        mon  = bcd_dec(i_data[39:32], i_cfg.binary_mode);
        yy   = bcd_dec(i_data[47:40], i_cfg.binary_mode);
        cen  = i_cfg.century_present ? bcd_dec(i_data[55:48], i_cfg.binary_mode)
                                     : DEFAULT_CENTURY;
        pm   = (hraw & PM_BIT_MASK) != 8'd0;
        if (i_cfg.hour24_mode) begin
            h8   = bcd_dec(hraw, i_cfg.binary_mode);
            ok_h = h8 <= 8'd23;
        end else begin
            h8   = bcd_dec(hraw & HOUR_12H_MASK, i_cfg.binary_mode);
            ok_h = (h8 >= 8'd1) && (h8 <= 8'd12);
            if (h8 == 8'd12) begin
                h8 = pm ? 8'd12 : 8'd0;
            end else if (pm) begin
                h8 = h8 + 8'd12;
            end
        end

        n_dec.ok   = ok_h && (sec <= 8'd59) && (min <= 8'd59) && (yy <= 8'd99)
                     && (cen <= 8'd99) && (mon >= 8'd1) && (mon <= 8'd12);
        n_dec.sec  = sec[5:0];
        n_dec.min  = min[5:0];
        n_dec.hour = h8[4:0];
        n_dec.day  = day;
        n_dec.mon  = mon[3:0];
        n_dec.yy   = yy[6:0];
        n_dec.cen  = cen[6:0];
        n_dec.year = 14'({7'd0, cen[6:0]} * 14'd100) + {7'd0, yy[6:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ce) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_dec <= n_dec;
        end
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;
endmodule

@@ sv/rtce_calendar.sv @@
// Stages 2 and 3: year and day checks, leap days, day of year, then day count
// and time of day. Depends on rtce_pkg.
module rtce_calendar (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_ce,
    input  logic            i_valid,
    input  rtce_pkg::t_dec  i_dec,
    output logic            o_valid,
    output rtce_pkg::t_days o_days
);
    import rtce_pkg::*;

    logic        r_valid2, r_valid3;
    t_cal        r_cal, n_cal;
    t_days       r_days, n_days;
    logic        leap;
    logic [4:0]  mlen;
    logic [6:0]  cp, yp;
    logic [11:0] lcount;
    logic signed [25:0] prod365;

    // leap-year count uses year-1 = 100*cp + yp
    always_comb begin
        leap   = ((i_dec.yy[1:0] == 2'd0) && (i_dec.yy != 7'd0))
                 || ((i_dec.yy == 7'd0) && (i_dec.cen[1:0] == 2'd0));
        mlen   = month_len(i_dec.mon);
        if ((i_dec.mon == 4'd2) && leap) begin
            mlen = 5'd29;
        end
        cp     = (i_dec.yy == 7'd0) ? i_dec.cen - 7'd1 : i_dec.cen;
        yp     = (i_dec.yy == 7'd0) ? 7'd99 : i_dec.yy - 7'd1;
        lcount = 12'({5'd0, cp} * 12'd24) + {7'd0, yp[6:2]} + {7'd0, cp[6:2]};

        n_cal.ok    = i_dec.ok && (i_dec.year >= MIN_YEAR) && (i_dec.year <= MAX_YEAR)
                      && (i_dec.day >= 8'd1) && (i_dec.day <= {3'd0, mlen});
        n_cal.ydiff = $signed({1'b0, i_dec.year}) - $signed(UNIX_BASE_YEAR);
        n_cal.leapd = $signed({1'b0, lcount}) - $signed({1'b0, LEAP_BIAS});
        n_cal.doy   = month_start(i_dec.mon)
                      + {8'd0, (i_dec.mon > 4'd2) && leap}
                      + {1'b0, i_dec.day} - 9'd1;
        n_cal.hour  = i_dec.hour;
        n_cal.min   = i_dec.min;
        n_cal.sec   = i_dec.sec;
    end

    always_comb begin
        prod365     = 26'(r_cal.ydiff) * 26'sd365;
        n_days.ok   = r_cal.ok;
        n_days.days = 24'(prod365 + 26'(r_cal.leapd) + $signed({17'd0, r_cal.doy}));
        n_days.tod  = 17'({12'd0, r_cal.hour} * 17'd3600)
                      + 17'({11'd0, r_cal.min} * 17'd60) + {11'd0, r_cal.sec};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid2 <= 1'b0;
            r_valid3 <= 1'b0;
        end else if (i_ce) begin
            r_valid2 <= i_valid;
            r_valid3 <= r_valid2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_cal  <= n_cal;
            r_days <= n_days;
        end
    end

    assign o_valid = r_valid3;
    assign o_days  = r_days;
endmodule

@@ sv/rtce_scale.sv @@
// Stages 4 and 5: days times 86400, then add time of day into the output register.
// Depends on rtce_pkg.
module rtce_scale (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_ce,
    input  logic            i_valid,
    input  rtce_pkg::t_days i_days,
    output logic            o_valid,
    output logic [38:0]     o_epoch,
    output logic            o_ok
);
    import rtce_pkg::*;

    logic               r_valid4, r_valid5;
    t_prod              r_prod, n_prod;
    logic signed [41:0] mul;
    logic signed [39:0] sum;
    logic [38:0]        r_epoch, n_epoch;
    logic               r_ok;

    always_comb begin
        mul         = 42'(i_days.days) * 42'sd86400;
        n_prod.ok   = i_days.ok;
        n_prod.prod = mul[39:0];
        n_prod.tod  = i_days.tod;
    end

    always_comb begin
        sum     = r_prod.prod + $signed({23'd0, r_prod.tod});
        n_epoch = r_prod.ok ? sum[38:0] : 39'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid4 <= 1'b0;
            r_valid5 <= 1'b0;
        end else if (i_ce) begin
            r_valid4 <= i_valid;
            r_valid5 <= r_valid4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_prod  <= n_prod;
            r_epoch <= n_epoch;
            r_ok    <= r_prod.ok;
        end
    end

    assign o_valid = r_valid5;
    assign o_epoch = r_epoch;
    assign o_ok    = r_ok;
endmodule

@@ sv/cmos_rtc_to_epoch_seconds.sv @@
// Top level: CMOS RTC snapshot to seconds since 1970-01-01 UTC.
// Depends on rtce_pkg, rtce_decode, rtce_calendar, rtce_scale.
//
// Channel  Dir  Handshake                 Payload
// -------  ---  ------------------------  ---------------------------------
// s        in   i_s_tvalid / o_s_tready   i_s_tdata: seven raw RTC bytes
// m        out  o_m_tvalid / i_m_tready   o_m_tdata: epoch, o_m_tuser: valid
// cfg      in   i_cfg_we                  i_cfg_idx, i_cfg_wdata
//
// Five register stages: decode, calendar check, day count, x86400, final add.
// One item per cycle sustained while the output is not held; o_m_tvalid rises once
// an accepted item has passed through the register stages above, in their order.
// The whole pipeline advances together; it holds only while the output item
// waits (o_m_tvalid high, i_m_tready low), so o_s_tready = !o_m_tvalid | i_m_tready.
// Synchronous active-low reset clears valid bits and config registers (all 0).
module cmos_rtc_to_epoch_seconds (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [0:0]  i_cfg_wdata,
    // input item stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [7:0] raw_second, [15:8] raw_minute, [23:16] raw_hour, [31:24] raw_day,
    // [39:32] raw_month, [47:40] raw_year, [55:48] raw_century
    input  logic [55:0] i_s_tdata,
    // result item stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [38:0] epoch_seconds (two's complement), [39] zero pad
    output logic [39:0] o_m_tdata,
    // [0] valid_res
    output logic [0:0]  o_m_tuser
);
    import rtce_pkg::*;

    t_cfg        r_cfg;
    logic        ce;
    logic        dec_valid, cal_valid, out_valid;
    t_dec        dec;
    t_days       days;
    logic [38:0] epoch;
    logic        ok;

    // config registers; an unused index is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BINARY_MODE:     r_cfg.binary_mode     <= i_cfg_wdata[0];
                CFG_HOUR24_MODE:     r_cfg.hour24_mode     <= i_cfg_wdata[0];
                CFG_CENTURY_PRESENT: r_cfg.century_present <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // pipeline moves unless the output item is stuck
    assign ce = !out_valid || i_m_tready;

    rtce_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_cfg   (r_cfg),
        .i_valid (i_s_tvalid),
        .i_data  (i_s_tdata),
        .o_valid (dec_valid),
        .o_dec   (dec)
    );

    rtce_calendar u_calendar (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (dec_valid),
        .i_dec   (dec),
        .o_valid (cal_valid),
        .o_days  (days)
    );

    rtce_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (cal_valid),
        .i_days  (days),
        .o_valid (out_valid),
        .o_epoch (epoch),
        .o_ok    (ok)
    );

    assign o_s_tready = ce;
    assign o_m_tvalid = out_valid;
    assign o_m_tdata  = {1'b0, epoch};
    assign o_m_tuser  = ok;
endmodule
